// File: design/nfrd_pkg.sv
// shared types, constants and the ordering function of the nearest-first drain unit
// no dependencies; imported by every module of the block
package nfrd_pkg;

  localparam int CAPACITY     = 32;
  localparam int COORD_BITS   = 16;
  localparam int HANDLE_BITS  = 8;
  localparam int RESULT_LIMIT = 32;
  localparam int OP_BITS      = 2;
  localparam int STATUS_BITS  = 2;
  localparam int DRAIN_BITS   = 6;
  localparam int Y_SHIFT      = 2;  // y distance weight of four

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int LIM_BITS = $clog2(RESULT_LIMIT + 1);
  localparam int MIN_BITS0 = (DRAIN_BITS > CNT_BITS) ? DRAIN_BITS : CNT_BITS;
  localparam int MIN_BITS  = (MIN_BITS0 > LIM_BITS) ? MIN_BITS0 : LIM_BITS;
  localparam int SQ_BITS  = 2 * COORD_BITS;
  localparam int KEY_BITS = 2 * COORD_BITS + 3;

  localparam logic [OP_BITS-1:0] OP_PUSH    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_OLDEST  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLOSEST = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_DRAINED = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_PUSHED  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NONE    = 2'd3;

  typedef logic [1:0] cell_cmd_t;
  localparam cell_cmd_t CMD_HOLD   = 2'd0;
  localparam cell_cmd_t CMD_LOAD   = 2'd1;
  localparam cell_cmd_t CMD_TAKE_R = 2'd2;
  localparam cell_cmd_t CMD_TAKE_L = 2'd3;

  localparam logic [1:0] PH_X = 2'd0;
  localparam logic [1:0] PH_Y = 2'd1;
  localparam logic [1:0] PH_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } coord_t;

  typedef struct packed {
    coord_t                 pos;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    entry_t              e;
    logic [KEY_BITS-1:0] key;
  } cell_t;

  typedef struct packed {
    logic       en;
    logic [1:0] phase;
  } key_ctrl_t;

  typedef struct packed {
    logic [OP_BITS-1:0]           operation;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [HANDLE_BITS-1:0]       handle;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic [DRAIN_BITS-1:0]        drain_count;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]       status;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic [HANDLE_BITS-1:0]       out_handle;
    logic                         last;
  } rsp_t;

  // true when a must sit strictly ahead of b: key, then y, x, z
  function automatic logic goes_before(cell_t a, cell_t b);
    logic res;
    if (a.key != b.key) begin
      res = (a.key < b.key);
    end else if (a.e.pos.y != b.e.pos.y) begin
      res = (a.e.pos.y < b.e.pos.y);
    end else if (a.e.pos.x != b.e.pos.x) begin
      res = (a.e.pos.x < b.e.pos.x);
    end else begin
      res = (a.e.pos.z < b.e.pos.z);
    end
    return res;
  endfunction

endpackage

// File: design/nfrd_cell.sv
// one storage cell of the entry chain: holds an entry and its distance key
// depends on nfrd_pkg
module nfrd_cell (
  input  logic              clk,
  input  nfrd_pkg::cell_cmd_t cmd,
  input  nfrd_pkg::entry_t  load_e,
  input  nfrd_pkg::cell_t   left_i,
  input  nfrd_pkg::cell_t   right_i,
  output nfrd_pkg::cell_t   q_o
);
  import nfrd_pkg::*;

  cell_t q_r, q_nxt;

  always_comb begin
    q_nxt = q_r;
    unique case (cmd)
      CMD_HOLD:   q_nxt = q_r;
      CMD_LOAD: begin
        q_nxt.e   = load_e;
        q_nxt.key = '0;
      end
      CMD_TAKE_R: q_nxt = right_i;
      CMD_TAKE_L: q_nxt = left_i;
      default:    q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

// File: design/nfrd_key_unit.sv
// weighted squared distance of the head entry, one axis square per cycle
// depends on nfrd_pkg
module nfrd_key_unit (
  input  logic                      clk,
  input  nfrd_pkg::key_ctrl_t       ctrl,
  input  nfrd_pkg::coord_t          pos,
  input  nfrd_pkg::coord_t          center,
  output logic [nfrd_pkg::KEY_BITS-1:0] key_o
);
  import nfrd_pkg::*;

  logic signed [COORD_BITS-1:0] a_sel, c_sel;
  logic signed [COORD_BITS:0]   diff;
  logic [COORD_BITS:0]          mag;
  logic [COORD_BITS-1:0]        absd;
  logic [SQ_BITS-1:0]           sq;
  logic [KEY_BITS-1:0]          acc_r, acc_nxt;

  always_comb begin
    unique case (ctrl.phase)
      PH_X: begin
        a_sel = pos.x;
        c_sel = center.x;
      end
      PH_Y: begin
        a_sel = pos.y;
        c_sel = center.y;
      end
      default: begin
        a_sel = pos.z;
        c_sel = center.z;
      end
    endcase
    diff = (COORD_BITS+1)'(a_sel) - (COORD_BITS+1)'(c_sel);
    mag  = diff[COORD_BITS] ? -diff : diff;
    absd = mag[COORD_BITS-1:0];
    sq   = SQ_BITS'(absd) * SQ_BITS'(absd);
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.en) begin
      if (ctrl.phase == PH_X) begin
        acc_nxt = KEY_BITS'(sq);
      end else if (ctrl.phase == PH_Y) begin
        acc_nxt = acc_r + (KEY_BITS'(sq) << Y_SHIFT);
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // final axis joins the accumulated sum on the way into the chain
  assign key_o = acc_r + KEY_BITS'(sq);

endmodule

// File: design/nearest_first_result_drain_unit.sv
// top level of the nearest-first result drain: control, chain of entry cells, key unit
// depends on nfrd_pkg, nfrd_cell and nfrd_key_unit
//
// Pending results live in a chain of CAPACITY cells, head at cell 0. A push is
// written straight into the cell at the fill count and answers with one result.
// A zero count, an empty buffer or an undefined code also answers with one
// result. A drain of the oldest entries emits one entry per cycle from the head,
// as long as the output is not stalled, while the chain shifts toward it. A
// closest drain first rotates the whole ring once through a single shared
// squarer at the head, taking the x, y and z squares of each cell in turn. Then
// count rounds of odd-even exchange between neighboring cells put the entries
// in order, and the emission follows at one entry a cycle while the output is
// not stalled. A new request is taken only once the previous one has produced
// all its results, but its last result may still sit in the output register
// waiting for the consumer.
module nearest_first_result_drain_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  nfrd_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output nfrd_pkg::rsp_t out_data
);
  import nfrd_pkg::*;

  // controller states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RESP = 3'd1;
  localparam logic [2:0] S_KEY  = 3'd2;
  localparam logic [2:0] S_SORT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;   // stored entries
  logic [CNT_BITS-1:0]    rem_r, rem_nxt;       // results still to emit
  logic [CNT_BITS-1:0]    pass_r, pass_nxt;     // exchange round
  logic [IDX_BITS-1:0]    rot_r, rot_nxt;       // ring rotation step
  logic [1:0]             phase_r, phase_nxt;   // key axis
  logic [STATUS_BITS-1:0] status_r, status_nxt; // single-result status
  coord_t                 center_r, center_nxt;

  logic out_valid_r, out_valid_nxt;
  rsp_t out_data_r, out_data_nxt;

  cell_t     cell_q   [CAPACITY];
  cell_cmd_t cell_cmd [CAPACITY];
  logic      swap     [CAPACITY];
  cell_t     tail_feed;
  entry_t    push_e;
  key_ctrl_t key_ctrl;
  logic [KEY_BITS-1:0] key_new;

  logic accept, slot_free, do_push;
  logic [MIN_BITS-1:0] take;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign do_push   = accept && (in_data.operation == OP_PUSH) &&
                     (count_r < CNT_BITS'(CAPACITY));

  assign push_e.pos.x  = in_data.coord_x;
  assign push_e.pos.y  = in_data.coord_y;
  assign push_e.pos.z  = in_data.coord_z;
  assign push_e.handle = in_data.handle;

  // number of entries a drain removes
  always_comb begin
    take = (MIN_BITS'(in_data.drain_count) < MIN_BITS'(count_r)) ?
           MIN_BITS'(in_data.drain_count) : MIN_BITS'(count_r);
    if (take > MIN_BITS'(RESULT_LIMIT)) begin
      take = MIN_BITS'(RESULT_LIMIT);
    end
  end

  // shared squarer sits on the head cell during the key sweep
  assign key_ctrl.en    = (state_r == S_KEY);
  assign key_ctrl.phase = phase_r;

  nfrd_key_unit u_key (
    .clk    (clk),
    .ctrl   (key_ctrl),
    .pos    (cell_q[0].e.pos),
    .center (center_r),
    .key_o  (key_new)
  );

  // head entry wraps to the tail with its fresh key
  assign tail_feed.e   = cell_q[0].e;
  assign tail_feed.key = key_new;

  // neighbor exchange decisions, pair (i, i+1) active on matching parity
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      swap[i] = 1'b0;
      if ((i < CAPACITY - 1) && (state_r == S_SORT) &&
          (1'(i) == pass_r[0]) &&
          (CNT_BITS'(i + 1) < count_r)) begin
        swap[i] = goes_before(cell_q[(i < CAPACITY - 1) ? i + 1 : i], cell_q[i]);
      end
    end
  end

  // per-cell commands
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_cmd[i] = CMD_HOLD;
      unique case (state_r)
        S_IDLE: begin
          if (do_push && (count_r == CNT_BITS'(i))) begin
            cell_cmd[i] = CMD_LOAD;
          end
        end
        S_KEY: begin
          if (phase_r == PH_Z) begin
            cell_cmd[i] = CMD_TAKE_R;
          end
        end
        S_SORT: begin
          if (swap[i]) begin
            cell_cmd[i] = CMD_TAKE_R;
          end else if ((i > 0) && swap[(i > 0) ? i - 1 : i]) begin
            cell_cmd[i] = CMD_TAKE_L;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            cell_cmd[i] = CMD_TAKE_R;
          end
        end
        default: cell_cmd[i] = CMD_HOLD;
      endcase
    end
  end

  // the chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    nfrd_cell u_cell (
      .clk     (clk),
      .cmd     (cell_cmd[g]),
      .load_e  (push_e),
      .left_i  (cell_q[(g > 0) ? g - 1 : g]),
      .right_i ((g < CAPACITY - 1) ? cell_q[(g < CAPACITY - 1) ? g + 1 : g] : tail_feed),
      .q_o     (cell_q[g])
    );
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    pass_nxt      = pass_r;
    rot_nxt       = rot_r;
    phase_nxt     = phase_r;
    status_nxt    = status_r;
    center_nxt    = center_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RESP;
          if (in_data.operation == OP_PUSH) begin
            if (do_push) begin
              count_nxt  = count_r + 1'b1;
              status_nxt = ST_PUSHED;
            end else begin
              status_nxt = ST_FULL;
            end
          end else if (((in_data.operation != OP_OLDEST) &&
                        (in_data.operation != OP_CLOSEST)) ||
                       (in_data.drain_count == '0) || (count_r == '0)) begin
            status_nxt = ST_NONE;
          end else begin
            rem_nxt = CNT_BITS'(take);
            if (in_data.operation == OP_CLOSEST) begin
              state_nxt    = S_KEY;
              rot_nxt      = '0;
              phase_nxt    = PH_X;
              center_nxt.x = in_data.center_x;
              center_nxt.y = in_data.center_y;
              center_nxt.z = in_data.center_z;
            end else begin
              state_nxt = S_EMIT;
            end
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = '0;
          out_data_nxt.status = status_r;
          out_data_nxt.last = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_KEY: begin
        if (phase_r == PH_Z) begin
          phase_nxt = PH_X;
          rot_nxt   = rot_r + 1'b1;
          if (rot_r == IDX_BITS'(CAPACITY - 1)) begin
            state_nxt = S_SORT;
            pass_nxt  = '0;
          end
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
      S_SORT: begin
        pass_nxt = pass_r + 1'b1;
        if (pass_r == count_r - 1'b1) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.status     = ST_DRAINED;
          out_data_nxt.out_x      = cell_q[0].e.pos.x;
          out_data_nxt.out_y      = cell_q[0].e.pos.y;
          out_data_nxt.out_z      = cell_q[0].e.pos.z;
          out_data_nxt.out_handle = cell_q[0].e.handle;
          out_data_nxt.last       = (rem_r == CNT_BITS'(1));
          count_nxt = count_r - 1'b1;
          rem_nxt   = rem_r - 1'b1;
          if (rem_r == CNT_BITS'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      pass_r      <= '0;
      rot_r       <= '0;
      phase_r     <= PH_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      pass_r      <= pass_nxt;
      rot_r       <= rot_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    center_r   <= center_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/nfrd_checker.sv
// port-level checks of the nearest-first drain unit, bound to its top level
// depends on nfrd_pkg and nearest_first_result_drain_unit
module nfrd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input nfrd_pkg::rsp_t out_data
);
  import nfrd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous still in work");

  // a drain still in progress blocks new requests
  a_no_req_mid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("request port open before drain finished");

  // push and empty answers are single results
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_DRAINED) |-> out_data.last)
    else $error("non-drain result without last");

endmodule

bind nearest_first_result_drain_unit nfrd_checker u_nfrd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
